/* hdl/pcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 24;

   localparam int SAMPLE_W = 16;
   localparam int CNT_W    = COUNT_BITS + 1;
   localparam int SX_W     = SAMPLE_BITS + COUNT_BITS + 1;
   localparam int SXX_W    = 2 * SAMPLE_BITS + COUNT_BITS - 1;
   localparam int SXY_W    = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int PROD1_W  = 2 * SAMPLE_BITS;

   // serial multiplier operand and product widths, wide enough for the
   // numerator and variance terms
   localparam int MUL_W  = 2 * SAMPLE_BITS + 2 * COUNT_BITS + 4;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SIGN_W = PROD_W + 2;
   localparam int DIV_W  = PROD_W + 1;

   localparam int FRAC_BITS = 30;
   localparam int QUO_W     = 2 * FRAC_BITS + 1;
   localparam int ROOT_W    = FRAC_BITS + 1;
   localparam int CNTD_W    = $clog2(QUO_W);
   localparam int BIT_W     = $clog2(ROOT_W);
   localparam int R_W       = 32;
   localparam int RSQ_W     = 31;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << COUNT_BITS;

   typedef struct packed {
      logic        [CNT_W-1:0] cnt;
      logic signed [SX_W-1:0]  sx;
      logic signed [SX_W-1:0]  sy;
      logic        [SXX_W-1:0] sxx;
      logic        [SXX_W-1:0] syy;
      logic signed [SXY_W-1:0] sxy;
   } set_sums_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NXY,
      ST_XY,
      ST_NXX,
      ST_XX,
      ST_NYY,
      ST_YY,
      ST_CHECK,
      ST_DEN,
      ST_NUM2,
      ST_DIV,
      ST_ROOT,
      ST_SQ,
      ST_FIN,
      ST_OUT
   } back_state_type;

   function automatic logic [MUL_W-1:0] mag_of(input logic signed [MUL_W-1:0] v);
      return v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
   endfunction

endpackage
`default_nettype wire

/* hdl/pcc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcc_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire pcc_pkg::set_sums_type push_data,
   input  wire logic                  pop,
   output      pcc_pkg::set_sums_type head_data,
   output      logic                  not_empty,
   output      logic [pcc_pkg::FIFO_CW-1:0] count
);
   import pcc_pkg::*;

   set_sums_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;
endmodule
`default_nettype wire

/* hdl/pcc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [15:0]           x_sample,
   input  wire logic [15:0]           y_sample,
   input  wire logic                  last_pair,
   input  wire logic [pcc_pkg::FIFO_CW-1:0] fifo_count,
   output      logic                  ready,
   output      logic                  push,
   output      pcc_pkg::set_sums_type push_data
);
   import pcc_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_last_ff;
   logic signed [SAMPLE_BITS-1:0] x_in, y_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff;
   logic        [PROD1_W-1:0]  pxx_ff, pyy_ff;
   logic signed [PROD1_W-1:0]  pxy_ff;
   set_sums_type               sums_ff, sums_in, sums_next;
   logic                       room;

   assign x_in = signed'(x_sample[SAMPLE_BITS-1:0]);
   assign y_in = signed'(y_sample[SAMPLE_BITS-1:0]);
   assign s1_valid_in = accept;

   // keep one queue slot back for a set closing in the product stage
   assign room  = (fifo_count < FIFO_CW'(FIFO_DEPTH - 1)) ||
                  ((fifo_count == FIFO_CW'(FIFO_DEPTH - 1)) && !(s1_valid_ff && s1_last_ff));
   assign ready = room;

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      s1_last_ff <= last_pair;
      pxx_ff     <= PROD1_W'(x_in * x_in);
      pyy_ff     <= PROD1_W'(y_in * y_in);
      pxy_ff     <= x_in * y_in;
   end

   always_comb begin
      sums_next = sums_ff;
      if (sums_ff.cnt < COUNT_LIMIT) begin
         sums_next.cnt = sums_ff.cnt + CNT_W'(1);
         sums_next.sx  = sums_ff.sx + SX_W'(x_ff);
         sums_next.sy  = sums_ff.sy + SX_W'(y_ff);
         sums_next.sxx = sums_ff.sxx + SXX_W'(pxx_ff);
         sums_next.syy = sums_ff.syy + SXX_W'(pyy_ff);
         sums_next.sxy = sums_ff.sxy + SXY_W'(pxy_ff);
      end
      sums_in = sums_ff;
      push    = 1'b0;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            push    = 1'b1;
            sums_in = '0;
         end else begin
            sums_in = sums_next;
         end
      end
   end

   assign push_data = sums_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sums_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         sums_ff     <= sums_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/pcc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcc_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pcc_pkg::MUL_W-1:0]  a,
   input  wire logic [pcc_pkg::MUL_W-1:0]  b,
   output      logic                       done,
   output      logic [pcc_pkg::PROD_W-1:0] product
);
   import pcc_pkg::*;

   logic              busy_ff, busy_in;
   logic [PROD_W-1:0] a_ff, a_in;
   logic [MUL_W-1:0]  b_ff, b_in;
   logic [PROD_W-1:0] acc_ff, acc_in;

   // shift-add, one multiplier bit a cycle; stop once the rest of b is zero
   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = PROD_W'(a);
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff != '0) begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = busy_ff && (b_ff == '0);
   assign product = acc_ff;
endmodule
`default_nettype wire

/* hdl/pcc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module pcc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pcc_pkg::set_sums_type head_data,
   input  wire logic                  not_empty,
   output      logic                  pop,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic [pcc_pkg::R_W-1:0]   corr_r,
   output      logic [pcc_pkg::RSQ_W-1:0] corr_r_squared,
   output      logic                  undefined_flag,
   output      logic [pcc_pkg::CNT_W-1:0] pair_count
);
   import pcc_pkg::*;

   back_state_type             state_ff, state_in;
   logic                       go_ff, go_in;
   set_sums_type               ent_ff, ent_in;
   logic signed [SIGN_W-1:0]   acc_ff, acc_in;
   logic signed [SIGN_W-1:0]   num_ff, num_in;
   logic signed [SIGN_W-1:0]   dx_ff, dx_in;
   logic signed [SIGN_W-1:0]   dy_ff, dy_in;
   logic        [PROD_W-1:0]   den_ff, den_in;
   logic        [DIV_W-1:0]    rem_ff, rem_in;
   logic        [QUO_W-1:0]    quo_ff, quo_in;
   logic        [CNTD_W-1:0]   dcnt_ff, dcnt_in;
   logic        [ROOT_W-1:0]   root_ff, root_in;
   logic        [BIT_W-1:0]    bit_ff, bit_in;
   logic        [2*ROOT_W-1:0] sq_ff, sq_in;
   logic        [R_W-1:0]      r_ff, r_in;
   logic        [RSQ_W-1:0]    rsq_ff, rsq_in;
   logic                       flag_ff, flag_in;

   logic        [MUL_W-1:0]    mul_a, mul_b;
   logic                       mul_neg;
   logic                       mul_done;
   logic        [PROD_W-1:0]   mul_p;
   logic signed [SIGN_W-1:0]   sprod;
   logic signed [SIGN_W-1:0]   num_abs;
   logic                       ge;
   logic        [DIV_W-1:0]    diff;
   logic        [ROOT_W-1:0]   trial;
   logic        [2*ROOT_W-1:0] trial_sq;

   pcc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   assign num_abs = num_ff[SIGN_W-1] ? -num_ff : num_ff;

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      unique case (state_ff)
         ST_NXY: begin
            mul_a   = MUL_W'(ent_ff.cnt);
            mul_b   = mag_of(MUL_W'(ent_ff.sxy));
            mul_neg = ent_ff.sxy[SXY_W-1];
         end
         ST_XY: begin
            mul_a   = mag_of(MUL_W'(ent_ff.sx));
            mul_b   = mag_of(MUL_W'(ent_ff.sy));
            mul_neg = ent_ff.sx[SX_W-1] ^ ent_ff.sy[SX_W-1];
         end
         ST_NXX: begin
            mul_a = MUL_W'(ent_ff.cnt);
            mul_b = MUL_W'(ent_ff.sxx);
         end
         ST_XX: begin
            mul_a = mag_of(MUL_W'(ent_ff.sx));
            mul_b = mag_of(MUL_W'(ent_ff.sx));
         end
         ST_NYY: begin
            mul_a = MUL_W'(ent_ff.cnt);
            mul_b = MUL_W'(ent_ff.syy);
         end
         ST_YY: begin
            mul_a = mag_of(MUL_W'(ent_ff.sy));
            mul_b = mag_of(MUL_W'(ent_ff.sy));
         end
         ST_DEN: begin
            mul_a = dx_ff[MUL_W-1:0];
            mul_b = dy_ff[MUL_W-1:0];
         end
         ST_NUM2: begin
            mul_a = num_abs[MUL_W-1:0];
            mul_b = num_abs[MUL_W-1:0];
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign sprod = mul_neg ? -SIGN_W'(mul_p) : SIGN_W'(mul_p);

   assign ge       = rem_ff >= DIV_W'(den_ff);
   assign diff     = ge ? rem_ff - DIV_W'(den_ff) : rem_ff;
   assign trial    = root_ff | (ROOT_W'(1) << bit_ff);
   assign trial_sq = trial * trial;

   always_comb begin
      state_in = state_ff;
      go_in    = 1'b0;
      ent_in   = ent_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dcnt_in  = dcnt_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      sq_in    = sq_ff;
      r_in     = r_ff;
      rsq_in   = rsq_ff;
      flag_in  = flag_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               ent_in   = head_data;
               go_in    = 1'b1;
               state_in = ST_NXY;
            end
         end
         ST_NXY: begin
            if (mul_done) begin
               acc_in   = sprod;
               go_in    = 1'b1;
               state_in = ST_XY;
            end
         end
         ST_XY: begin
            if (mul_done) begin
               num_in   = acc_ff - sprod;
               go_in    = 1'b1;
               state_in = ST_NXX;
            end
         end
         ST_NXX: begin
            if (mul_done) begin
               acc_in   = sprod;
               go_in    = 1'b1;
               state_in = ST_XX;
            end
         end
         ST_XX: begin
            if (mul_done) begin
               dx_in    = acc_ff - sprod;
               go_in    = 1'b1;
               state_in = ST_NYY;
            end
         end
         ST_NYY: begin
            if (mul_done) begin
               acc_in   = sprod;
               go_in    = 1'b1;
               state_in = ST_YY;
            end
         end
         ST_YY: begin
            if (mul_done) begin
               dy_in    = acc_ff - sprod;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((dx_ff == '0) || (dy_ff == '0)) begin
               r_in     = '0;
               rsq_in   = '0;
               flag_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               go_in    = 1'b1;
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            if (mul_done) begin
               den_in   = mul_p;
               go_in    = 1'b1;
               state_in = ST_NUM2;
            end
         end
         ST_NUM2: begin
            if (mul_done) begin
               rem_in   = DIV_W'(mul_p);
               quo_in   = '0;
               dcnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide: num^2 <= den, so one integer bit then fraction bits
            quo_in = {quo_ff[QUO_W-2:0], ge};
            if (dcnt_ff == CNTD_W'(QUO_W - 1)) begin
               root_in  = '0;
               bit_in   = BIT_W'(ROOT_W - 1);
               state_in = ST_ROOT;
            end else begin
               rem_in  = diff << 1;
               dcnt_in = dcnt_ff + CNTD_W'(1);
            end
         end
         ST_ROOT: begin
            if (trial_sq <= (2*ROOT_W)'(quo_ff)) begin
               root_in = trial;
            end
            if (bit_ff == '0) begin
               state_in = ST_SQ;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_SQ: begin
            sq_in    = root_ff * root_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            r_in     = num_ff[SIGN_W-1] ? -R_W'(root_ff) : R_W'(root_ff);
            rsq_in   = sq_ff[FRAC_BITS +: RSQ_W];
            flag_in  = 1'b0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      sq_ff   <= sq_in;
      r_ff    <= r_in;
      rsq_ff  <= rsq_in;
      flag_ff <= flag_in;
   end

   assign out_valid      = (state_ff == ST_OUT);
   assign corr_r         = r_ff;
   assign corr_r_squared = rsq_ff;
   assign undefined_flag = flag_ff;
   assign pair_count     = ent_ff.cnt;
endmodule
`default_nettype wire

/* hdl/pearson_correlation_unit.sv */
// Pearson correlation over streamed sample pairs.
// Input stream req_*: one pair per beat, tlast marks the last pair of a set.
// Output stream rsp_*: one beat per finished set with r in Q2.30 and r squared in
// Q1.30, the pair count, and tuser high when a variance is zero (r, r^2 = 0).
// The front accumulates one pair per cycle through a two-stage product and
// sum pipeline; a closed set's sums go into a four-entry queue.
// The back works through one set at a time on a shared shift-add multiplier
// (up to eight products), a restoring divide that yields a 61-bit quotient
// and a bit-by-bit square root that yields a 31-bit root.
// Input beats keep flowing at one per cycle until the queue fills up with
// finished sets; then req_tready drops until the back takes one.
// A stalled rsp_tready holds the result beat and the back, not the front.
// Reset clears all sums, empties the queue and returns the back to idle.
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // x_sample[15:0], y_sample[31:16]
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [87:0] rsp_tdata,   // corr_r[31:0], corr_r_squared[62:32],
                                         // pair_count[87:63]
   output      logic        rsp_tuser    // undefined_flag
);
   import pcc_pkg::*;

   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 not_empty;
   logic [FIFO_CW-1:0]   fifo_count;
   set_sums_type         push_data;
   set_sums_type         head_data;
   logic [R_W-1:0]       corr_r;
   logic [RSQ_W-1:0]     corr_r_squared;
   logic [CNT_W-1:0]     pair_count;

   assign accept = req_tvalid && req_tready;

   pcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .x_sample   (req_tdata[15:0]),
      .y_sample   (req_tdata[31:16]),
      .last_pair  (req_tlast),
      .fifo_count (fifo_count),
      .ready      (req_tready),
      .push       (push),
      .push_data  (push_data)
   );

   pcc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .not_empty (not_empty),
      .count     (fifo_count)
   );

   pcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_data      (head_data),
      .not_empty      (not_empty),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .corr_r         (corr_r),
      .corr_r_squared (corr_r_squared),
      .undefined_flag (rsp_tuser),
      .pair_count     (pair_count)
   );

   assign rsp_tdata = {pair_count, corr_r_squared, corr_r};
endmodule
`default_nettype wire

/* tb/tb_pearson_correlation_unit.sv */
`timescale 1ns / 1ps
module tb_pearson_correlation_unit;
   import pcc_pkg::*;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } pair_type;

   typedef struct {
      logic [31:0] r;
      logic [30:0] rsq;
      logic        undef;
      logic [24:0] count;
   } corr_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // x_sample[15:0], y_sample[31:16]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // corr_r[31:0], corr_r_squared[62:32], pair_count[87:63]
   logic        rsp_tuser;   // undefined_flag

   pair_type  pending_pairs[$];
   corr_type  expected_corr[$];
   longint acc_x, acc_y, acc_xx, acc_yy, acc_xy;
   int     acc_n;
   int     errors = 0;
   int     results_seen = 0;
   int     pairs_sent = 0;
   int     sets_sent = 0;
   int     hold_cycles = 0;
   bit     hold_done = 0;
   bit     req_fire = 0;
   int     idle_cycles = 0;
   int     cyc = 0;

   pearson_correlation_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
   endtask

   // accumulate one pair; on the last pair of a set queue the coefficient
   task automatic accumulate_pair(input logic [15:0] xs, input logic [15:0] ys,
                                  input logic last);
      longint x, y;
      wide_type  n, num, dx, dy, mag, den, lim, lhs;
      longint unsigned lo, hi, mid;
      bit     neg;
      corr_type  c;
      x = longint'($signed(xs));
      y = longint'($signed(ys));
      if (acc_n < (1 << COUNT_BITS)) begin
         acc_x += x; acc_y += y;
         acc_xx += x * x; acc_yy += y * y; acc_xy += x * y;
         acc_n++;
      end
      if (!last) return;
      n   = wide_type'(acc_n);
      num = n * wide_type'(acc_xy) - wide_type'(acc_x) * wide_type'(acc_y);
      dx  = n * wide_type'(acc_xx) - wide_type'(acc_x) * wide_type'(acc_x);
      dy  = n * wide_type'(acc_yy) - wide_type'(acc_y) * wide_type'(acc_y);
      c.count = acc_n[24:0];
      if (dx == 0 || dy == 0) begin
         c.r = 0; c.rsq = 0; c.undef = 1;
      end else begin
         neg = num < 0;
         mag = neg ? -num : num;
         den = dx * dy;
         lim = (mag * mag) <<< 60;
         lo = 0;
         hi = 64'd1 << 30;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = wide_type'(mid * mid) * den;
            if (lhs <= lim) lo = mid;
            else hi = mid - 1;
         end
         c.r     = neg ? 32'(-lo) : 32'(lo);
         c.rsq   = 31'((lo * lo) >> 30);
         c.undef = 0;
      end
      expected_corr.push_back(c);
      acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_n = 0;
   endtask

   function automatic bit quiet_stretch();
      return cyc > 4000 && cyc < 9000;
   endfunction

   // sender
   always @(negedge clock) begin
      pair_type p;
      cyc <= cyc + 1;
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_pairs.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 37)) begin
            p = pending_pairs.pop_front();
            req_tdata  <= {p.y, p.x};
            req_tlast  <= p.last;
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver ready, with one long hold-off so the set queue fills up
   always @(negedge clock) begin
      if (!hold_done && results_seen == 5) begin
         hold_done   <= 1;
         hold_cycles <= 3000;
         rsp_tready  <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 0;
      end else begin
         rsp_tready <= reset ? 1'b0 : (quiet_stretch() || $urandom_range(99) >= 37);
      end
   end

   // input predictor and result checker
   always @(posedge clock) begin
      corr_type c;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         accumulate_pair(req_tdata[15:0], req_tdata[31:16], req_tlast);
         pairs_sent++;
         if (req_tlast) sets_sent++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_corr.size() == 0) begin
            report("unexpected beat", rsp_tdata[31:0], 0);
         end else begin
            c = expected_corr.pop_front();
            if (rsp_tdata[31:0] !== c.r) report("corr_r", rsp_tdata[31:0], c.r);
            if (rsp_tdata[62:32] !== c.rsq) report("corr_r_squared", rsp_tdata[62:32], c.rsq);
            if (rsp_tdata[87:63] !== c.count) report("pair_count", rsp_tdata[87:63], c.count);
            if (rsp_tuser !== c.undef) report("undefined_flag", rsp_tuser, c.undef);
         end
         results_seen++;
      end
   end

   // watchdog on stalled progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("timeout: no beat for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic add_pair(input int x, input int y, input bit last);
      pair_type p;
      p.x = 16'(x); p.y = 16'(y); p.last = last;
      pending_pairs.push_back(p);
   endtask

   initial begin
      int len, mode, x, y, total;
      reset = 1;
      req_tvalid = 0; req_tdata = 0; req_tlast = 0; rsp_tready = 0;
      acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_n = 0;
      // single pair: zero variance
      add_pair(0, 0, 1);
      // extremes, perfectly anti-correlated
      add_pair(-32768, 32767, 0);
      add_pair(32767, -32768, 1);
      // constant x
      add_pair(5, 100, 0); add_pair(5, -7, 0); add_pair(5, 3, 1);
      // constant y
      add_pair(1, -32768, 0); add_pair(-9, -32768, 1);
      // y equals x at extremes
      add_pair(-32768, -32768, 0); add_pair(32767, 32767, 0);
      add_pair(0, 0, 0); add_pair(-1, -1, 1);
      // loosely correlated
      add_pair(10, 12, 0); add_pair(20, 18, 0); add_pair(30, 33, 0); add_pair(-40, -35, 1);
      total = 0;
      while (total < 500) begin
         len  = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 16);
         mode = $urandom_range(3);
         for (int i = 0; i < len; i++) begin
            x = $urandom_range(65535);
            case (mode)
               0: y = $urandom_range(65535);
               1: y = $signed(16'(x)) + $signed(16'($urandom_range(63))) - 32;
               2: y = -int'($signed(16'(x))) / 2 + int'($urandom_range(1000));
               default: y = $urandom_range(65535);
            endcase
            if (mode == 3 && i == 0) x = 16'h7fff;
            add_pair(x, y, i == len - 1);
         end
         total += len;
      end
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 0;
      wait (pending_pairs.size() == 0 && !req_tvalid);
      wait (expected_corr.size() == 0);
      repeat (700) @(posedge clock);
      $display("covered %0d pairs in %0d sets, %0d result beats checked",
               pairs_sent, sets_sent, results_seen);
      $display("with one long receiver hold-off and random idling on both streams");
      if (errors == 0 && expected_corr.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
